[rtl/mtvf_pkg.sv]
// mtvf_pkg: shared types and codes of the multi-track volume fade engine
// no dependencies

package mtvf_pkg;

	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_TICK   = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [2:0] ST_QUEUED  = 3'd0;
	localparam logic [2:0] ST_APPLIED = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_TICK    = 3'd3;
	localparam logic [2:0] ST_QUERY   = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  track_id;
		logic [15:0] start_volume;
		logic [15:0] target_volume;
		logic [31:0] duration_us;
		logic        is_fade_out;
		logic [23:0] delta_us;
	} req_t;

	typedef struct packed {
		logic [7:0]  out_track;
		logic [15:0] out_volume;
		logic        volume_valid;
		logic        stop_track;
		logic        fade_active;
		logic [2:0]  status;
		logic        last;
	} rsp_t;

endpackage

[rtl/mtvf_divider.sv]
// mtvf_divider: restoring divider, one quotient bit per cycle
// depends on nothing; returns floor of num/den and a nonzero-remainder flag for a 48-bit numerator

module mtvf_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [47:0] quo,
	output logic        rem_nz
);

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q[31:0], quo_q[47]};
	assign diff    = shifted - {1'b0, den_q};

	// one shift-subtract step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				if (!diff[32]) begin
					rem_q <= diff;
					quo_q <= {quo_q[46:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[46:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo    = quo_q;
	assign rem_nz = (rem_q != '0);

endmodule

[rtl/mtvf_front.sv]
// mtvf_front: input stage and request queue of the fade engine
// depends on mtvf_pkg

module mtvf_front #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mtvf_pkg::req_t  in_item,
	output logic            q_valid,
	input  logic            q_pop,
	output mtvf_pkg::req_t  q_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	mtvf_pkg::req_t  mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     cnt_q;
	logic            push;

	// drop unknown requests here so the back end only sees real work
	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign push     = in_valid && in_ready && (in_item.req_type != mtvf_pkg::REQ_UNUSED);
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				mem_q[wr_q] <= in_item;
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end

endmodule

[rtl/mtvf_back.sv]
// mtvf_back: slot table and sequencer that carries out each request
// depends on mtvf_pkg and mtvf_divider

module mtvf_back #(
	parameter int MAX_FADES = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_pop,
	input  mtvf_pkg::req_t  q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output mtvf_pkg::rsp_t  out_item
);

	localparam int SW = (MAX_FADES > 1) ? $clog2(MAX_FADES) : 1;
	localparam logic [SW:0] SLOT_END = (SW+1)'(MAX_FADES);
	localparam logic [SW:0] SLOT_ONE = (SW+1)'(1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_VOL, S_DIV, S_EMIT, S_NEXT
	} state_t;

	state_t          state_q;
	mtvf_pkg::req_t  req_q;
	logic [SW:0]     idx_q;
	logic [SW:0]     hit_q;
	logic [SW:0]     free_q;

	logic [MAX_FADES-1:0] valid_q;
	logic [7:0]      trk_q  [MAX_FADES];
	logic [15:0]     from_q [MAX_FADES];
	logic [15:0]     to_q   [MAX_FADES];
	logic [31:0]     dur_q  [MAX_FADES];
	logic [31:0]     el_q   [MAX_FADES];
	logic            stp_q  [MAX_FADES];

	logic [SW-1:0]   sidx;
	logic [SW-1:0]   cidx;
	logic [15:0]     cfrom, cto;
	logic [31:0]     cdur, cel;
	logic            down;
	logic [15:0]     span;
	logic [47:0]     prod;
	logic            div_start, div_done, div_rnz;
	logic [47:0]     div_quo;
	logic [15:0]     step;
	logic [15:0]     vol;
	logic [15:0]     cur_vol;
	logic            at_end;
	logic [32:0]     esum;
	logic [31:0]     enew;
	logic            any_later;
	logic            hit_found;
	logic            free_found;
	logic            emit_fire;
	logic            timed_start;
	logic [SW-1:0]   load_idx;
	mtvf_pkg::rsp_t  emit_item;

	assign sidx  = idx_q[SW-1:0];
	// slot whose volume is being computed
	assign cidx  = (req_q.req_type == mtvf_pkg::REQ_TICK) ? sidx : hit_q[SW-1:0];
	assign cfrom = from_q[cidx];
	assign cto   = to_q[cidx];
	assign cdur  = dur_q[cidx];
	assign cel   = el_q[cidx];
	assign down  = cto < cfrom;
	assign span  = down ? cfrom - cto : cto - cfrom;
	assign prod  = span * cel;

	mtvf_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(prod), .den(cdur), .done(div_done),
		.quo(div_quo), .rem_nz(div_rnz)
	);

	assign step    = down ? 16'(div_quo) + 16'(div_rnz) : 16'(div_quo);
	assign vol     = down ? cfrom - step : cfrom + step;
	assign at_end  = (cel >= cdur);
	assign cur_vol = at_end ? cto : vol;
	assign esum    = {1'b0, el_q[sidx]} + 33'(req_q.delta_us);
	assign enew    = (esum > {1'b0, dur_q[sidx]}) ? dur_q[sidx] : esum[31:0];

	assign hit_found   = (hit_q != SLOT_END);
	assign free_found  = (free_q != SLOT_END);
	assign timed_start = (req_q.req_type == mtvf_pkg::REQ_START) &&
	                     (req_q.duration_us != '0);
	assign load_idx    = hit_found ? hit_q[SW-1:0] : free_q[SW-1:0];

	// is there a valid slot after the current one
	always_comb begin
		any_later = 1'b0;
		for (int i = 0; i < MAX_FADES; i++)
			if (valid_q[i] && (i > int'(idx_q))) any_later = 1'b1;
	end

	// result item of the current step
	always_comb begin
		emit_item = '0;
		emit_item.out_track = req_q.track_id;
		emit_item.last      = 1'b1;
		unique case (req_q.req_type)
			mtvf_pkg::REQ_TICK: begin
				emit_item.out_track    = trk_q[sidx];
				emit_item.out_volume   = cur_vol;
				emit_item.volume_valid = 1'b1;
				emit_item.stop_track   = at_end && stp_q[sidx];
				emit_item.status       = mtvf_pkg::ST_TICK;
				emit_item.last         = !any_later;
			end
			mtvf_pkg::REQ_QUERY: begin
				emit_item.fade_active = hit_found;
				emit_item.status      = mtvf_pkg::ST_QUERY;
			end
			default: begin
				if (req_q.duration_us == '0) begin
					emit_item.status       = mtvf_pkg::ST_APPLIED;
					emit_item.volume_valid = 1'b1;
					emit_item.stop_track   = req_q.is_fade_out;
					emit_item.out_volume   = req_q.is_fade_out ? 16'd0
					                         : req_q.target_volume;
				end else if (hit_found || free_found) begin
					emit_item.status = mtvf_pkg::ST_QUEUED;
				end else begin
					emit_item.status = mtvf_pkg::ST_FULL;
				end
			end
		endcase
	end

	assign emit_fire = (state_q == S_EMIT) && (!out_valid || out_ready);
	assign div_start = (state_q == S_VOL);
	assign q_pop     = (state_q == S_IDLE) && q_valid && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			out_valid <= 1'b0;
			out_item  <= '0;
			idx_q     <= '0;
		end else begin
			// output register
			if (emit_fire) begin
				out_valid <= 1'b1;
				out_item  <= emit_item;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (q_pop) begin
					req_q   <= q_item;
					idx_q   <= '0;
					hit_q   <= SLOT_END;
					free_q  <= SLOT_END;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// walk slots: find the track and lowest free slot, or for a tick the next valid one
					if (req_q.req_type == mtvf_pkg::REQ_TICK) begin
						if (idx_q == SLOT_END) state_q <= S_IDLE;
						else if (valid_q[sidx]) begin
							el_q[sidx] <= enew;
							state_q    <= S_VOL;
						end else idx_q <= idx_q + SLOT_ONE;
					end else if (idx_q == SLOT_END) begin
						if (timed_start && hit_found) state_q <= S_VOL;
						else state_q <= S_EMIT;
					end else begin
						if (valid_q[sidx] && trk_q[sidx] == req_q.track_id &&
						    hit_q == SLOT_END) hit_q <= idx_q;
						if (!valid_q[sidx] && free_q == SLOT_END)
							free_q <= idx_q;
						idx_q <= idx_q + SLOT_ONE;
					end
				end
				S_VOL: state_q <= S_DIV;
				S_DIV: if (div_done) state_q <= S_EMIT;
				S_EMIT: if (emit_fire) begin
					if (req_q.req_type == mtvf_pkg::REQ_TICK) begin
						if (at_end) valid_q[sidx] <= 1'b0;
						idx_q   <= idx_q + SLOT_ONE;
						state_q <= any_later ? S_SCAN : S_IDLE;
					end else begin
						state_q <= S_IDLE;
						// load the slot; a restart begins from the current volume, a new fade from start_volume
						if (timed_start && (hit_found || free_found)) begin
							if (hit_found) begin
								from_q[load_idx] <= cur_vol;
							end else begin
								from_q[load_idx] <= req_q.start_volume;
								trk_q[load_idx]  <= req_q.track_id;
							end
							valid_q[load_idx] <= 1'b1;
							to_q[load_idx]    <= req_q.target_volume;
							dur_q[load_idx]   <= req_q.duration_us;
							el_q[load_idx]    <= '0;
							stp_q[load_idx]   <= req_q.is_fade_out;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/multi_track_volume_fade_engine.sv]
// multi_track_volume_fade_engine: top level of the fade engine
// depends on mtvf_pkg, mtvf_front, mtvf_back
//
// Requests enter a two-entry queue and are carried out one at a time by a
// slot sequencer, which takes the next item only once the previous result has
// left the output register. A start or query walks the MAX_FADES slots (one
// slot a cycle) and answers with one item; restarting a running fade also
// finds its current volume with the shift-subtract divider. A tick walks the
// slots the same way, one slot a cycle past idle slots; each active fade goes
// through divider setup, divide and output before the walk moves on. Output
// stalls hold the sequencer in its output step. Request code 3 is accepted
// and dropped.

module multi_track_volume_fade_engine #(
	parameter int MAX_FADES = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mtvf_pkg::req_t  in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output mtvf_pkg::rsp_t  out_item
);

	logic            q_valid;
	logic            q_pop;
	mtvf_pkg::req_t  q_item;

	mtvf_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	mtvf_back #(.MAX_FADES(MAX_FADES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_item(q_item), .out_valid(out_valid), .out_ready(out_ready),
		.out_item(out_item)
	);

endmodule
